// ===== rtl/case_insensitive_find_replace_top_macros.svh =====
// assertion macros for the find and replace block
// used by the checker module; expects signals clock and reset in scope
`ifndef CASE_INSENSITIVE_FIND_REPLACE_TOP_MACROS_SVH
`define CASE_INSENSITIVE_FIND_REPLACE_TOP_MACROS_SVH

// checked while out of reset
`define CIFR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// checked on every edge, reset included
`define CIFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/cifr_pkg.sv =====
// shared types and constants of the find and replace block
// no dependencies
package cifr_pkg;

   localparam int TEXT_BYTES = 8;
   localparam int LEN_W      = 4;
   localparam int POS_W      = 3;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [1:0] {
      CSR_PATTERN_TEXT,
      CSR_PATTERN_LEN,
      CSR_REPLACEMENT_TEXT,
      CSR_REPLACEMENT_LEN
   } cifr_csr_index_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } cifr_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } cifr_rsp_type;

   typedef struct packed {
      logic                  we;
      cifr_csr_index_type    index;
      logic [CSR_DATA_W-1:0] data;
   } cifr_csr_type;

   // bytes to emit for one transaction, count is at least one
   typedef struct packed {
      logic [TEXT_BYTES-1:0][7:0] bytes;
      logic [LEN_W-1:0]           count;
   } cifr_job_type;

endpackage

// ===== rtl/cifr_front.sv =====
// front end: config registers, byte window, pattern compare, job build
// depends on cifr_pkg
module cifr_front #(
   parameter int MAX_LEN = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cifr_pkg::cifr_csr_type csr,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cifr_pkg::cifr_req_type req_payload,
   input  logic                  queue_full,
   output logic                  push_valid,
   output cifr_pkg::cifr_job_type push_job
);
   import cifr_pkg::*;

   logic [CSR_DATA_W-1:0] pattern_ff;
   logic [CSR_DATA_W-1:0] replacement_ff;
   logic [LEN_W-1:0]      pattern_len_ff;
   logic [LEN_W-1:0]      replacement_len_ff;
   logic [LEN_W-1:0]      fill_ff, fill_in;
   logic [7:0]            win_ff   [MAX_LEN];
   logic [7:0]            win_in   [MAX_LEN];
   logic [7:0]            win_next [MAX_LEN];
   logic [7:0]            win_shift[MAX_LEN];
   logic [TEXT_BYTES-1:0][7:0] win_word;

   logic [LEN_W-1:0] plen, rlen, fill_eff, fill_new;
   logic             accept, full_now, match;

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7a) begin
         return c - 8'h20;
      end
      return c;
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (pattern_len_ff == '0) begin
         plen = LEN_W'(1);
      end else if (pattern_len_ff > LEN_W'(MAX_LEN)) begin
         plen = LEN_W'(MAX_LEN);
      end else begin
         plen = pattern_len_ff;
      end
      rlen     = (replacement_len_ff > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : replacement_len_ff;
      fill_eff = (fill_ff >= plen) ? '0 : fill_ff;
      fill_new = fill_eff + LEN_W'(1);
      full_now = (fill_new == plen);
   end

   always_comb begin
      match = 1'b1;
      for (int k = 0; k < MAX_LEN; k++) begin
         win_next[k] = (fill_eff == LEN_W'(k)) ? req_payload.in_byte : win_ff[k];
      end
      for (int k = 0; k < MAX_LEN; k++) begin
         if (LEN_W'(k) < plen &&
             fold_upper(win_next[k]) != fold_upper(pattern_ff[8*k +: 8])) begin
            match = 1'b0;
         end
      end
      for (int k = 0; k < MAX_LEN - 1; k++) begin
         win_shift[k] = win_next[k+1];
      end
      win_shift[MAX_LEN-1] = win_next[MAX_LEN-1];
   end

   for (genvar g = 0; g < TEXT_BYTES; g++) begin : g_word
      if (g < MAX_LEN) begin : g_used
         assign win_word[g] = win_next[g];
      end else begin : g_pad
         assign win_word[g] = 8'h00;
      end
   end

   always_comb begin
      fill_in        = fill_ff;
      win_in         = win_ff;
      push_valid     = 1'b0;
      push_job.bytes = win_word;
      push_job.count = fill_new;
      if (accept) begin
         priority if (full_now && match) begin
            push_valid     = (rlen != '0);
            push_job.bytes = replacement_ff;
            push_job.count = rlen;
            fill_in        = '0;
         end else if (full_now) begin
            push_valid     = 1'b1;
            push_job.count = req_payload.end_of_stream ? plen : LEN_W'(1);
            win_in         = win_shift;
            fill_in        = req_payload.end_of_stream ? '0 : plen - LEN_W'(1);
         end else begin
            push_valid = req_payload.end_of_stream;
            win_in     = win_next;
            fill_in    = req_payload.end_of_stream ? '0 : fill_new;
         end
      end
      if (csr.we && csr.index == CSR_PATTERN_LEN) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff         <= '0;
         replacement_ff     <= '0;
         pattern_len_ff     <= LEN_W'(1);
         replacement_len_ff <= '0;
         fill_ff            <= '0;
      end else begin
         fill_ff <= fill_in;
         if (csr.we) begin
            unique case (csr.index)
               CSR_PATTERN_TEXT:     pattern_ff         <= csr.data;
               CSR_PATTERN_LEN:      pattern_len_ff     <= csr.data[LEN_W-1:0];
               CSR_REPLACEMENT_TEXT: replacement_ff     <= csr.data;
               CSR_REPLACEMENT_LEN:  replacement_len_ff <= csr.data[LEN_W-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

// ===== rtl/cifr_queue.sv =====
// two-entry job queue between front and back end
// depends on cifr_pkg
module cifr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  cifr_pkg::cifr_job_type push_job,
   output logic                  full,
   input  logic                  pop,
   output logic                  pop_valid,
   output cifr_pkg::cifr_job_type pop_job
);
   import cifr_pkg::*;

   cifr_job_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/cifr_back.sv =====
// back end: plays out the bytes of each job, one per cycle while rsp_ready is high
// depends on cifr_pkg
module cifr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  cifr_pkg::cifr_job_type job,
   output logic                  job_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cifr_pkg::cifr_rsp_type rsp_payload
);
   import cifr_pkg::*;

   cifr_job_type     job_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             busy_ff, busy_in;
   logic             take, last, load;

   assign rsp_valid            = busy_ff;
   assign last                 = ({1'b0, pos_ff} == job_ff.count - LEN_W'(1));
   assign rsp_payload.out_byte = job_ff.bytes[pos_ff];
   assign rsp_payload.run_last = last;
   assign take                 = busy_ff && rsp_ready;
   assign load                 = (!busy_ff || (take && last)) && job_valid;
   assign job_pop              = load;

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      priority if (load) begin
         busy_in = 1'b1;
         pos_in  = '0;
      end else if (take && last) begin
         busy_in = 1'b0;
      end else if (take) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job;
      end
   end

endmodule

// ===== rtl/case_insensitive_find_replace_top.sv =====
// top level of the case-insensitive streaming find and replace block
// depends on cifr_pkg, cifr_front, cifr_queue, cifr_back
//
//   port group  direction  payload
//   req_        in         in_byte, end_of_stream
//   rsp_        out        out_byte, run_last
//   csr_        in         write of pattern and replacement registers
//
// one input transaction per cycle while the job queue has room
// the back end sends result bytes one at a time, stalling on rsp_ready;
// a match emits replacement_len bytes (at most MAX_LEN), an end of stream
// flushes up to MAX_LEN bytes; results pass queue and back end registers
// synchronous reset clears window fill, queue and back end, no clearing pass
module case_insensitive_find_replace_top #(
   parameter int MAX_LEN = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cifr_pkg::cifr_req_type        req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cifr_pkg::cifr_rsp_type        rsp_payload,
   input  logic                          csr_we,
   input  cifr_pkg::cifr_csr_index_type  csr_index,
   input  logic [cifr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cifr_pkg::*;

   cifr_csr_type csr;
   cifr_job_type push_job, pop_job;
   logic         push_valid, queue_full, pop, pop_valid;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   cifr_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   cifr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job)
   );

   cifr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (pop_valid),
      .job         (pop_job),
      .job_pop     (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/cifr_checker.sv =====
// port-level assertions for the find and replace top level
// depends on cifr_pkg and case_insensitive_find_replace_top_macros.svh
`include "case_insensitive_find_replace_top_macros.svh"

module cifr_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input cifr_pkg::cifr_rsp_type rsp_payload
);
   import cifr_pkg::*;

   // a stalled result holds
   `CIFR_ASSERT_NEXT(a_rsp_hold, !reset && rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   // nothing pending straight after reset
   `CIFR_ASSERT_NEXT(a_reset_idle, reset, !rsp_valid && req_ready)
   // queue never fills while the back end is idle
   `CIFR_ASSERT_IMPL(a_idle_ready, !rsp_valid, req_ready)
   // a presented result carries known bytes
   `CIFR_ASSERT_IMPL(a_rsp_known, rsp_valid, !$isunknown(rsp_payload))

endmodule

bind case_insensitive_find_replace_top cifr_checker u_checker (.*);
